>>> design/lsps_pkg.sv
// ----------------------------------------------------------------------------
// Light sensor power sampler package
// Shared types, constants and the trimmed-mean scaling function.
// ----------------------------------------------------------------------------
package lsps_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [11:0] AdcMax      = 12'd4095;
  localparam logic [4:0]  BurstLen    = 5'd16;
  localparam logic [15:0] PeriodReset = 16'd1000;
  localparam logic [9:0]  SettleReset = 10'd10;
  localparam logic [11:0] PresReset   = 12'd4;
  localparam logic [16:0] RoundAdd    = 17'd7;
  localparam logic [15:0] Recip7      = 16'd37450;
  localparam int unsigned Recip7Shift = 18;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_CONV  = 2'd1,
    ACT_START = 2'd2
  } lsps_action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE       = 2'd0,
    CFG_PERIOD       = 2'd1,
    CFG_SETTLE       = 2'd2,
    CFG_PRESENCE_MIN = 2'd3
  } lsps_cfg_idx_e;

  typedef struct packed {
    logic        enable;
    logic [15:0] sample_period_ms;
    logic [9:0]  settle_ms;
    logic [11:0] presence_min;
  } lsps_cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic        adc_ok;
    logic [11:0] adc_raw;
  } lsps_item_t;

  typedef struct packed {
    logic        power_on;
    logic        burst_wanted;
    logic        sample_valid;
    logic [11:0] sample_value;
  } lsps_res_t;

  // (x + 7) / 14 as ((x + 7) >> 1) / 7, the latter by reciprocal multiply
  function automatic logic [11:0] lsps_div14(input logic [15:0] x);
    logic [16:0] rounded;
    logic [15:0] half;
    logic [31:0] prod;
    rounded = {1'b0, x} + RoundAdd;
    half    = rounded[16:1];
    prod    = half * Recip7;
    return prod[Recip7Shift+11:Recip7Shift];
  endfunction

endpackage

>>> design/lsps_if.sv
// ----------------------------------------------------------------------------
// Light sensor power sampler channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface lsps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] now_ms;
  logic        adc_ok;
  logic [11:0] adc_raw;

  modport source (output valid, action, now_ms, adc_ok, adc_raw, input ready);
  modport sink   (input valid, action, now_ms, adc_ok, adc_raw, output ready);
endinterface

interface lsps_out_if;
  logic        valid;
  logic        ready;
  logic        power_on;
  logic        burst_wanted;
  logic        sample_valid;
  logic [11:0] sample_value;

  modport source (output valid, power_on, burst_wanted, sample_valid, sample_value,
                  input ready);
  modport sink   (input valid, power_on, burst_wanted, sample_valid, sample_value,
                  output ready);
endinterface

>>> design/lsps_core.sv
// ----------------------------------------------------------------------------
// Light sensor power sampler core
// Measurement state and the per-transaction next-state and result logic.
// ----------------------------------------------------------------------------
module lsps_core
  import lsps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  lsps_cfg_t  cfg_i,
  input  lsps_item_t item_i,
  output lsps_res_t  res_o
);

  logic        powered_q, powered_d;
  logic        pres_done_q, pres_done_d;
  logic        in_burst_q, in_burst_d;
  logic [31:0] last_time_q, last_time_d;
  logic [31:0] pstart_q, pstart_d;
  logic [4:0]  count_q, count_d;
  logic [11:0] min_q, min_d;
  logic [11:0] max_q, max_d;
  logic [15:0] sum_q, sum_d;

  logic [31:0] since_last;
  logic [31:0] since_power;
  logic [11:0] raw_sat;
  logic [11:0] min_n;
  logic [11:0] max_n;
  logic [15:0] sum_n;
  logic [15:0] trimmed;
  logic        sv;
  logic [11:0] sval;

  always_comb begin
    since_last  = item_i.now_ms - last_time_q;
    since_power = item_i.now_ms - pstart_q;
    raw_sat     = (item_i.adc_raw > AdcMax) ? AdcMax : item_i.adc_raw;
    min_n       = (raw_sat < min_q) ? raw_sat : min_q;
    max_n       = (raw_sat > max_q) ? raw_sat : max_q;
    sum_n       = sum_q + {4'd0, raw_sat};
    trimmed     = sum_n - {4'd0, min_n} - {4'd0, max_n};
  end

  always_comb begin
    powered_d   = powered_q;
    pres_done_d = pres_done_q;
    in_burst_d  = in_burst_q;
    last_time_d = last_time_q;
    pstart_d    = pstart_q;
    count_d     = count_q;
    min_d       = min_q;
    max_d       = max_q;
    sum_d       = sum_q;
    sv          = 1'b0;
    sval        = '0;
    case (lsps_action_e'(item_i.action))
      ACT_START: begin
        last_time_d = item_i.now_ms - {16'd0, cfg_i.sample_period_ms};
      end
      ACT_TICK: begin
        if (cfg_i.enable && !in_burst_q) begin
          if (!powered_q) begin
            if (since_last >= {16'd0, cfg_i.sample_period_ms}) begin
              pres_done_d = 1'b0;
              powered_d   = 1'b1;
              pstart_d    = item_i.now_ms;
            end
          end else if (since_power >= {22'd0, cfg_i.settle_ms}) begin
            if (!pres_done_q) begin
              if (!item_i.adc_ok || (item_i.adc_raw <= cfg_i.presence_min)) begin
                powered_d   = 1'b0;
                in_burst_d  = 1'b0;
                last_time_d = item_i.now_ms;
                sv          = 1'b1;
              end else begin
                pstart_d    = item_i.now_ms;
                pres_done_d = 1'b1;
              end
            end else begin
              in_burst_d = 1'b1;
              count_d    = '0;
              min_d      = AdcMax;
              max_d      = '0;
              sum_d      = '0;
            end
          end
        end
      end
      ACT_CONV: begin
        if (cfg_i.enable && in_burst_q) begin
          if (!item_i.adc_ok) begin
            powered_d   = 1'b0;
            in_burst_d  = 1'b0;
            last_time_d = item_i.now_ms;
          end else begin
            min_d   = min_n;
            max_d   = max_n;
            sum_d   = sum_n;
            count_d = count_q + 5'd1;
            if (count_d >= BurstLen) begin
              powered_d   = 1'b0;
              in_burst_d  = 1'b0;
              last_time_d = item_i.now_ms;
              pres_done_d = 1'b0;
              sv          = 1'b1;
              sval        = lsps_div14(trimmed);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      powered_q   <= 1'b0;
      pres_done_q <= 1'b0;
      in_burst_q  <= 1'b0;
      last_time_q <= '0;
      pstart_q    <= '0;
      count_q     <= '0;
      min_q       <= AdcMax;
      max_q       <= '0;
      sum_q       <= '0;
    end else if (step_i) begin
      powered_q   <= powered_d;
      pres_done_q <= pres_done_d;
      in_burst_q  <= in_burst_d;
      last_time_q <= last_time_d;
      pstart_q    <= pstart_d;
      count_q     <= count_d;
      min_q       <= min_d;
      max_q       <= max_d;
      sum_q       <= sum_d;
    end
  end

  assign res_o.power_on     = powered_d;
  assign res_o.burst_wanted = in_burst_d;
  assign res_o.sample_valid = sv;
  assign res_o.sample_value = sval;

endmodule

>>> design/light_sensor_power_sampler.sv
// ----------------------------------------------------------------------------
// Light sensor power sampler
// Duty-cycles a light sensor and delivers trimmed-mean brightness samples.
// ----------------------------------------------------------------------------
// Pipeline: each input transaction passes an input register and then a result
//   register; the state update sits between them.
// Throughput: one transaction per cycle, limited by the output handshake.
// Reset: rst_ni clears sensor state and loads the default register values.
module light_sensor_power_sampler
  import lsps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  lsps_in_if.sink             in_i,
  lsps_out_if.source          out_o
);

  lsps_cfg_t  cfg_q;
  logic       item_vld_q;
  lsps_item_t item_q;
  logic       res_vld_q;
  lsps_res_t  res_q;
  lsps_res_t  res_d;
  logic       advance;
  logic       step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable           <= 1'b1;
      cfg_q.sample_period_ms <= PeriodReset;
      cfg_q.settle_ms        <= SettleReset;
      cfg_q.presence_min     <= PresReset;
    end else if (cfg_we_i) begin
      case (lsps_cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE:       cfg_q.enable           <= cfg_data_i[0];
        CFG_PERIOD:       cfg_q.sample_period_ms <= cfg_data_i;
        CFG_SETTLE:       cfg_q.settle_ms        <= cfg_data_i[9:0];
        CFG_PRESENCE_MIN: cfg_q.presence_min     <= cfg_data_i[11:0];
        default: begin
        end
      endcase
    end
  end

  assign advance  = !res_vld_q || out_o.ready;
  assign step     = item_vld_q && advance;
  assign in_i.ready = !item_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.action  <= in_i.action;
      item_q.now_ms  <= in_i.now_ms;
      item_q.adc_ok  <= in_i.adc_ok;
      item_q.adc_raw <= in_i.adc_raw;
    end
  end

  lsps_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = res_vld_q;
  assign out_o.power_on     = res_q.power_on;
  assign out_o.burst_wanted = res_q.burst_wanted;
  assign out_o.sample_valid = res_q.sample_valid;
  assign out_o.sample_value = res_q.sample_value;

endmodule
